FILE: hw/rtl/pbui_pkg.sv
// Shared types and constants for the power bank user interface controller.
package pbui_pkg;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } pbui_event_e;

  typedef enum logic [1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_LEVEL    = 2'd1,
    MODE_CHARGING = 2'd2,
    MODE_FULL     = 2'd3
  } pbui_mode_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned BlinkW    = 8;
  localparam int unsigned CountW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_BLINK_LIMIT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHOW_TICKS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT_SENSE = 2'd2;

  localparam logic [BlinkW-1:0] BLINK_LIMIT_RST = 8'd50;
  localparam logic [CountW-1:0] SHOW_TICKS_RST  = 16'd500;

  typedef struct packed {
    logic [BlinkW-1:0] blink_limit;
    logic [CountW-1:0] show_ticks;
    logic              current_sense_enable;
  } pbui_cfg_t;

  typedef struct packed {
    logic [1:0] button_event;
    logic       charger_connected;
    logic       charge_current;
    logic       relay_on;
  } pbui_item_t;

  typedef struct packed {
    logic [1:0] display_mode;
    logic       blink_phase;
    logic       flashlight_on;
  } pbui_result_t;

endpackage

FILE: hw/rtl/power_bank_ui_controller_core.sv
// Top level: configuration registers, input word register and result register.
// A single pass of tick logic takes the input word into the result register.
// Throughput: one word per cycle while the output is not stalled.
// The input register takes one more word while the result waits, then it stalls.
// Reset (rst_ni low, asynchronous) empties both registers, clears all tick
// state and loads the configuration defaults.
module power_bank_ui_controller_core import pbui_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          button_event_i,
  input  logic                charger_connected_i,
  input  logic                charge_current_i,
  input  logic                relay_on_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          display_mode_o,
  output logic                blink_phase_o,
  output logic                flashlight_on_o
);

  pbui_cfg_t    cfg_q;
  logic         in_valid_q;
  pbui_item_t   in_item_q;
  logic         out_valid_q;
  pbui_result_t out_res_q;
  pbui_result_t step_res;
  logic         out_free;
  logic         step;
  logic         in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_limit          <= BLINK_LIMIT_RST;
      cfg_q.show_ticks           <= SHOW_TICKS_RST;
      cfg_q.current_sense_enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLINK_LIMIT:   cfg_q.blink_limit          <= cfg_data_i[BlinkW-1:0];
        CFG_SHOW_TICKS:    cfg_q.show_ticks           <= cfg_data_i[CountW-1:0];
        CFG_CURRENT_SENSE: cfg_q.current_sense_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.button_event      <= button_event_i;
      in_item_q.charger_connected <= charger_connected_i;
      in_item_q.charge_current    <= charge_current_i;
      in_item_q.relay_on          <= relay_on_i;
    end
    if (step) begin
      out_res_q <= step_res;
    end
  end

  pbui_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  assign out_valid_o     = out_valid_q;
  assign display_mode_o  = out_res_q.display_mode;
  assign blink_phase_o   = out_res_q.blink_phase;
  assign flashlight_on_o = out_res_q.flashlight_on;

endmodule

FILE: hw/rtl/pbui_core.sv
// Controller state registers and the single-tick update logic.
module pbui_core import pbui_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  pbui_item_t   item_i,
  input  pbui_cfg_t    cfg_i,
  output pbui_result_t res_o
);

  logic [BlinkW-1:0] blink_count_q, blink_count_d;
  logic              blink_level_q, blink_level_d;
  logic              show_level_q, show_level_d;
  logic              long_done_q, long_done_d;
  logic [CountW-1:0] countdown_q, countdown_d;
  logic              prev_charger_q, prev_charger_d;
  logic              lamp_q, lamp_d;
  logic [1:0]        mode;
  logic [BlinkW-1:0] blink_inc;

  always_comb begin
    blink_count_d  = blink_count_q;
    blink_level_d  = blink_level_q;
    show_level_d   = show_level_q;
    long_done_d    = long_done_q;
    countdown_d    = countdown_q;
    lamp_d         = lamp_q;
    prev_charger_d = item_i.charger_connected;
    mode           = MODE_CLEAR;

    // Unplugging drops whatever was shown.
    if (prev_charger_q && !item_i.charger_connected) begin
      show_level_d = 1'b0;
      countdown_d  = '0;
    end

    blink_inc = blink_count_q + BlinkW'(1);
    if (blink_inc >= cfg_i.blink_limit) begin
      blink_count_d = '0;
      blink_level_d = ~blink_level_q;
    end else begin
      blink_count_d = blink_inc;
    end

    if (!item_i.charger_connected) begin
      case (item_i.button_event)
        EV_PRESS: begin
          long_done_d = 1'b0;
        end
        EV_LONG: begin
          long_done_d  = 1'b1;
          show_level_d = 1'b0;
          countdown_d  = '0;
        end
        EV_RELEASE: begin
          if (!long_done_q) begin
            show_level_d = 1'b1;
            countdown_d  = cfg_i.show_ticks;
          end else begin
            show_level_d = 1'b0;
            countdown_d  = '0;
          end
        end
        default: ;
      endcase
    end else begin
      show_level_d = 1'b1;
      countdown_d  = '0;
    end

    if (item_i.button_event == EV_LONG) begin
      lamp_d = ~lamp_q;
    end

    if (!show_level_d) begin
      mode = MODE_CLEAR;
    end else if (item_i.charger_connected) begin
      mode = (cfg_i.current_sense_enable && !item_i.charge_current) ?
             MODE_FULL : MODE_CHARGING;
    end else begin
      mode = MODE_LEVEL;
      // A countdown that runs out in this tick already clears the display.
      if (countdown_d != '0) begin
        countdown_d = countdown_d - CountW'(1);
        if (countdown_d == '0) begin
          show_level_d = 1'b0;
          mode         = MODE_CLEAR;
        end
      end
    end

    if (!item_i.relay_on) begin
      lamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_count_q  <= '0;
      blink_level_q  <= 1'b0;
      show_level_q   <= 1'b0;
      long_done_q    <= 1'b0;
      countdown_q    <= '0;
      prev_charger_q <= 1'b0;
      lamp_q         <= 1'b0;
    end else if (step_i) begin
      blink_count_q  <= blink_count_d;
      blink_level_q  <= blink_level_d;
      show_level_q   <= show_level_d;
      long_done_q    <= long_done_d;
      countdown_q    <= countdown_d;
      prev_charger_q <= prev_charger_d;
      lamp_q         <= lamp_d;
    end
  end

  assign res_o.display_mode  = mode;
  assign res_o.blink_phase   = blink_level_d;
  assign res_o.flashlight_on = lamp_d;

endmodule

FILE: hw/rtl/pbui_checker.sv
// Port-level checker for the controller top level, with its bind statement.
module pbui_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] display_mode_o,
  input logic       blink_phase_o,
  input logic       flashlight_on_o
);

  // A result word waiting on a stall stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(display_mode_o) &&
    $stable(blink_phase_o) && $stable(flashlight_on_o))
    else $error("stalled result word changed");

  // A word that is accepted shows up at the output as a valid result word.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted word did not reach the output");

  // The input side only stalls behind a full, stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind power_bank_ui_controller_core pbui_checker u_pbui_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .display_mode_o  (display_mode_o),
  .blink_phase_o   (blink_phase_o),
  .flashlight_on_o (flashlight_on_o)
);
